### hdl/bgs_pkg.sv
// ----------------------------------------------------------------------------
// bgs_pkg: shared types and constants of the blast gate sequencer
// Command, mode and state codes, table sizes and the servo angle function.
// ----------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

	localparam int GATE_COUNT = 6;
	localparam int GATE_W     = 3;
	localparam int POS_DEPTH  = 2 * GATE_COUNT;
	localparam int POS_AW     = GATE_W + 1;

	localparam logic [GATE_W-1:0] NO_GATE   = 3'd7;
	localparam logic [GATE_W-1:0] LAST_GATE = GATE_W'(GATE_COUNT - 1);

	localparam logic [7:0] POS_RESET      = 8'd128;
	localparam logic [7:0] DEBOUNCE_RESET = 8'd30;
	localparam logic [7:0] COUNT_MAX      = 8'd255;

	// Register index, taken from paddr[2].
	localparam logic REG_DEBOUNCE = 1'b0;

	typedef enum logic [1:0] {
		CMD_SERVO = 2'd0,
		CMD_ON    = 2'd1,
		CMD_OFF   = 2'd2,
		CMD_BEEP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL    = 2'd0,
		MODE_PROG      = 2'd1,
		MODE_SET_CLOSE = 2'd2,
		MODE_SET_OPEN  = 2'd3
	} mode_t;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_DEB       = 13'b0000000000010,
		S_N_BEEP1   = 13'b0000000000100,
		S_N_TOGGLE  = 13'b0000000001000,
		S_N_OPEN    = 13'b0000000010000,
		S_N_ON      = 13'b0000000100000,
		S_N_SCAN    = 13'b0000001000000,
		S_P_BEEP1   = 13'b0000010000000,
		S_P_SERVO   = 13'b0000100000000,
		S_BEEP2     = 13'b0001000000000,
		S_BEEP_LAST = 13'b0010000000000,
		S_LIVE      = 13'b0100000000000,
		S_FLUSH     = 13'b1000000000000
	} state_t;

	// 90 + (pos - 128) / 2 with the division truncated toward zero.
	function automatic logic [7:0] angle_of(input logic [7:0] pos);
		logic signed [8:0] d;
		logic signed [8:0] half;
		logic signed [8:0] sum;
		d = $signed({1'b0, pos}) - 9'sd128;
		if (d < 0) begin
			half = (d + 9'sd1) >>> 1;
		end else begin
			half = d >>> 1;
		end
		sum = half + 9'sd90;
		return sum[7:0];
	endfunction

endpackage

`default_nettype wire

### hdl/blast_gate_sequencer.sv
// ----------------------------------------------------------------------------
// blast_gate_sequencer
// Debounces the gate buttons of each tick item and steps a small sequencer
// through the presses, issuing servo, collector and beep commands in order.
// ----------------------------------------------------------------------------
// One item at a time. An enter-programming item only switches to programming mode
// and clears the selected gate. A tick item with no press is accepted, debounces the
// six buttons in turn, makes the live write and finishes; a press adds its commands,
// and the close writes of an opening press are made in a scan over the six gates.
// Output stalls lengthen an item. Reset marks all gates closed, stops the collector,
// sets every stored position to 128 and the debounce threshold to 30.
`default_nettype none

module blast_gate_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic [bgs_pkg::GATE_COUNT-1:0] button_levels,
	input  wire logic [9:0]                     knob_sample,
	// result items
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          command,
	output logic [bgs_pkg::GATE_W-1:0]          gate_number,
	output logic [7:0]                          servo_angle,
	output logic                                last_of_run,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int GC = bgs_pkg::GATE_COUNT;
	localparam int GW = bgs_pkg::GATE_W;

	bgs_pkg::state_t             state_q;
	bgs_pkg::mode_t              mode_q;
	logic [7:0]                  deb_q;
	logic [GC-1:0]               open_q;
	logic                        running_q;
	logic [7:0]                  pos_q [bgs_pkg::POS_DEPTH];
	logic [GW-1:0]               sel_q;
	logic [GC-1:0]               prev_raw_q;
	logic [GC-1:0]               stable_q;
	logic [7:0]                  steady_q [GC];
	logic [GC-1:0]               lvl_q;
	logic [7:0]                  knob_q;
	logic [GW-1:0]               i_q;
	logic [GW-1:0]               g_q;
	logic [GW-1:0]               j_q;

	// one-deep holding stage so that the last command of an item can be marked
	logic                        pend_v_q;
	logic [1:0]                  pend_cmd_q;
	logic [GW-1:0]               pend_gate_q;
	logic [7:0]                  pend_angle_q;
	logic                        out_valid_q;
	logic [1:0]                  out_cmd_q;
	logic [GW-1:0]               out_gate_q;
	logic [7:0]                  out_angle_q;
	logic                        out_last_q;

	// debounce of the current button
	logic                        raw;
	logic [7:0]                  cnt_new;
	logic                        lvl_take;
	logic                        pressed;
	logic                        at_last;

	// command generation
	logic                        emit_req;
	bgs_pkg::cmd_t               emit_cmd;
	logic [GW-1:0]               emit_gate;
	logic                        use_knob;
	logic [bgs_pkg::POS_AW-1:0]  pos_addr;
	logic [7:0]                  pos_rd;
	logic [7:0]                  angle;
	logic                        scan_hit;
	logic                        live_on;
	logic                        out_free;
	logic                        can_emit;
	logic                        do_emit;
	logic                        flush;
	logic                        move;
	logic                        stall;
	logic                        cfg_wr;

	assign in_ready    = (state_q == bgs_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign command     = out_cmd_q;
	assign gate_number = out_gate_q;
	assign servo_angle = out_angle_q;
	assign last_of_run = out_last_q;
	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite && pready && (paddr[2] == bgs_pkg::REG_DEBOUNCE);
	assign prdata      = (paddr[2] == bgs_pkg::REG_DEBOUNCE) ? {24'd0, deb_q} : 32'd0;

	always_comb begin
		raw = lvl_q[i_q];
		if (raw != prev_raw_q[i_q]) begin
			cnt_new = 8'd0;
		end else if (steady_q[i_q] == bgs_pkg::COUNT_MAX) begin
			cnt_new = bgs_pkg::COUNT_MAX;
		end else begin
			cnt_new = steady_q[i_q] + 8'd1;
		end
		lvl_take = (cnt_new > deb_q) && (raw != stable_q[i_q]);
		pressed  = lvl_take && raw;
	end

	assign at_last  = (i_q == bgs_pkg::LAST_GATE);
	assign scan_hit = (j_q != g_q) && open_q[j_q];
	assign live_on  = (mode_q == bgs_pkg::MODE_SET_OPEN) || (mode_q == bgs_pkg::MODE_SET_CLOSE);
	assign pos_addr = (state_q == bgs_pkg::S_N_OPEN) ? {g_q, 1'b0} : {j_q, 1'b1};
	assign pos_rd   = pos_q[pos_addr];
	assign angle    = bgs_pkg::angle_of(use_knob ? knob_q : pos_rd);

	always_comb begin
		emit_req  = 1'b0;
		emit_cmd  = bgs_pkg::CMD_BEEP;
		emit_gate = '0;
		use_knob  = 1'b0;
		unique case (state_q)
			bgs_pkg::S_N_BEEP1, bgs_pkg::S_P_BEEP1, bgs_pkg::S_BEEP2,
			bgs_pkg::S_BEEP_LAST: begin
				emit_req = 1'b1;
			end
			bgs_pkg::S_N_TOGGLE: begin
				emit_req = 1'b1;
				emit_cmd = running_q ? bgs_pkg::CMD_OFF : bgs_pkg::CMD_ON;
			end
			bgs_pkg::S_N_ON: begin
				emit_req = 1'b1;
				emit_cmd = bgs_pkg::CMD_ON;
			end
			bgs_pkg::S_N_OPEN: begin
				emit_req  = 1'b1;
				emit_cmd  = bgs_pkg::CMD_SERVO;
				emit_gate = g_q;
			end
			bgs_pkg::S_N_SCAN: begin
				emit_req  = scan_hit;
				emit_cmd  = bgs_pkg::CMD_SERVO;
				emit_gate = j_q;
			end
			bgs_pkg::S_P_SERVO: begin
				emit_req  = 1'b1;
				emit_cmd  = bgs_pkg::CMD_SERVO;
				emit_gate = g_q;
				use_knob  = 1'b1;
			end
			bgs_pkg::S_LIVE: begin
				emit_req  = live_on;
				emit_cmd  = bgs_pkg::CMD_SERVO;
				emit_gate = sel_q;
				use_knob  = 1'b1;
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign can_emit = !pend_v_q || out_free;
	assign do_emit  = emit_req && can_emit;
	assign flush    = (state_q == bgs_pkg::S_FLUSH) && pend_v_q && out_free;
	assign move     = (do_emit && pend_v_q) || flush;
	assign stall    = emit_req && !can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_emit) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_cmd_q   <= pend_cmd_q;
			out_gate_q  <= pend_gate_q;
			out_angle_q <= pend_angle_q;
			out_last_q  <= flush;
		end
		if (do_emit) begin
			pend_cmd_q   <= emit_cmd;
			pend_gate_q  <= emit_gate;
			pend_angle_q <= (emit_cmd == bgs_pkg::CMD_SERVO) ? angle : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bgs_pkg::S_IDLE;
			mode_q     <= bgs_pkg::MODE_NORMAL;
			deb_q      <= bgs_pkg::DEBOUNCE_RESET;
			open_q     <= '0;
			running_q  <= 1'b0;
			sel_q      <= bgs_pkg::NO_GATE;
			prev_raw_q <= '1;
			stable_q   <= '0;
			lvl_q      <= '0;
			knob_q     <= '0;
			i_q        <= '0;
			g_q        <= '0;
			j_q        <= '0;
			for (int k = 0; k < bgs_pkg::POS_DEPTH; k++) begin
				pos_q[k] <= bgs_pkg::POS_RESET;
			end
			for (int k = 0; k < GC; k++) begin
				steady_q[k] <= bgs_pkg::COUNT_MAX;
			end
		end else begin
			if (cfg_wr) begin
				deb_q <= pwdata[7:0];
			end
			if (!stall) begin
				unique case (state_q)
					bgs_pkg::S_IDLE: begin
						if (in_valid) begin
							if (operation) begin
								mode_q <= bgs_pkg::MODE_PROG;
								sel_q  <= bgs_pkg::NO_GATE;
							end else begin
								lvl_q   <= button_levels;
								knob_q  <= knob_sample[9:2];
								i_q     <= '0;
								state_q <= bgs_pkg::S_DEB;
							end
						end
					end
					bgs_pkg::S_DEB: begin
						steady_q[i_q]   <= cnt_new;
						prev_raw_q[i_q] <= raw;
						if (lvl_take) begin
							stable_q[i_q] <= raw;
						end
						g_q <= i_q;
						if (pressed) begin
							state_q <= (mode_q == bgs_pkg::MODE_NORMAL) ?
							           bgs_pkg::S_N_BEEP1 : bgs_pkg::S_P_BEEP1;
						end else if (at_last) begin
							state_q <= bgs_pkg::S_LIVE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
					bgs_pkg::S_N_BEEP1: begin
						state_q <= open_q[g_q] ? bgs_pkg::S_N_TOGGLE : bgs_pkg::S_N_OPEN;
					end
					bgs_pkg::S_N_TOGGLE: begin
						running_q <= !running_q;
						if (at_last) begin
							state_q <= bgs_pkg::S_LIVE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= bgs_pkg::S_DEB;
						end
					end
					bgs_pkg::S_N_OPEN: begin
						open_q[g_q] <= 1'b1;
						j_q         <= '0;
						state_q     <= running_q ? bgs_pkg::S_N_SCAN : bgs_pkg::S_N_ON;
					end
					bgs_pkg::S_N_ON: begin
						running_q <= 1'b1;
						state_q   <= bgs_pkg::S_N_SCAN;
					end
					bgs_pkg::S_N_SCAN: begin
						// One gate a cycle unless the output stalls; every other open gate is driven to its close position.
						if (scan_hit) begin
							open_q[j_q] <= 1'b0;
						end
						if (j_q == bgs_pkg::LAST_GATE) begin
							state_q <= bgs_pkg::S_BEEP2;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					bgs_pkg::S_P_BEEP1: begin
						if (g_q != sel_q) begin
							sel_q  <= g_q;
							mode_q <= bgs_pkg::MODE_SET_OPEN;
							if (at_last) begin
								state_q <= bgs_pkg::S_LIVE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= bgs_pkg::S_DEB;
							end
						end else if (mode_q == bgs_pkg::MODE_SET_OPEN) begin
							pos_q[{g_q, 1'b0}] <= knob_q;
							mode_q             <= bgs_pkg::MODE_SET_CLOSE;
							state_q            <= bgs_pkg::S_BEEP_LAST;
						end else if (mode_q == bgs_pkg::MODE_SET_CLOSE) begin
							pos_q[{g_q, 1'b1}] <= knob_q;
							mode_q             <= bgs_pkg::MODE_PROG;
							sel_q              <= bgs_pkg::NO_GATE;
							state_q            <= bgs_pkg::S_P_SERVO;
						end else if (at_last) begin
							state_q <= bgs_pkg::S_LIVE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= bgs_pkg::S_DEB;
						end
					end
					bgs_pkg::S_P_SERVO: begin
						state_q <= bgs_pkg::S_BEEP2;
					end
					bgs_pkg::S_BEEP2: begin
						state_q <= bgs_pkg::S_BEEP_LAST;
					end
					bgs_pkg::S_BEEP_LAST: begin
						if (at_last) begin
							state_q <= bgs_pkg::S_LIVE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= bgs_pkg::S_DEB;
						end
					end
					bgs_pkg::S_LIVE: begin
						state_q <= bgs_pkg::S_FLUSH;
					end
					bgs_pkg::S_FLUSH: begin
						if (!pend_v_q || out_free) begin
							state_q <= bgs_pkg::S_IDLE;
						end
					end
					default: begin
						state_q <= bgs_pkg::S_IDLE;
					end
				endcase
			end
		end
	end

	// The held command must have gone out before a new item is taken.
	a_idle_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_v_q)
		else $error("command still held while ready for a new item");

	// Between items at most one gate is left open.
	a_one_gate_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgs_pkg::S_IDLE) |-> ($countones(open_q) <= 1))
		else $error("more than one gate open between items");

	// A capture in progress always names a gate.
	a_capture_has_gate: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == bgs_pkg::MODE_SET_OPEN) || (mode_q == bgs_pkg::MODE_SET_CLOSE))
		|-> (sel_q != bgs_pkg::NO_GATE))
		else $error("capture mode without a selected gate");

	// Entering programming mode aborts any capture at once.
	a_enter_prog: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation)
		|=> ((mode_q == bgs_pkg::MODE_PROG) && (sel_q == bgs_pkg::NO_GATE)))
		else $error("enter-programming item not applied");

endmodule

`default_nettype wire
